>>> hw/rtl/qrt_pkg.sv
package qrt_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int MATRIX_FRAC_BITS_DEF = 16;
   localparam int QUAT_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NORM_WIDTH = 34;   // sum of four 31-bit squares
   localparam int NUM_WIDTH = 36;    // signed matrix numerators

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_QUAT_W  = 3'd0,
      REG_QUAT_X  = 3'd1,
      REG_QUAT_Y  = 3'd2,
      REG_QUAT_Z  = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5,
      REG_SHIFT_Z = 3'd6,
      REG_NONE    = 3'd7
   } csr_index_type;

   // status between the matrix builder and the datapath
   typedef struct packed {
      logic busy;
      logic zero_quat;
   } mat_status_type;

endpackage

>>> hw/rtl/qrt_matrix_builder.sv
// Rebuilds the rotation matrix after each quaternion write. Products are
// formed in the IDLE and SQUARE states, then the nine entries are divided one
// at a time by a restoring divider, one quotient bit per cycle.
module qrt_matrix_builder #(
   parameter int MATRIX_FRAC_BITS = qrt_pkg::MATRIX_FRAC_BITS_DEF,
   parameter int MW = MATRIX_FRAC_BITS + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [qrt_pkg::QUAT_WIDTH-1:0] quat_w,
   input  logic signed [qrt_pkg::QUAT_WIDTH-1:0] quat_x,
   input  logic signed [qrt_pkg::QUAT_WIDTH-1:0] quat_y,
   input  logic signed [qrt_pkg::QUAT_WIDTH-1:0] quat_z,
   output logic signed [MW-1:0]                  matrix [9],
   output qrt_pkg::mat_status_type               status
);
   localparam int NW = qrt_pkg::NORM_WIDTH;
   localparam int UW = qrt_pkg::NUM_WIDTH;
   // dividend: 2*|num|<<F + n, quotient fits MW bits
   localparam int DW = UW + MATRIX_FRAC_BITS + 2;
   localparam int QB = MATRIX_FRAC_BITS + 2;
   // counts every dividend bit
   localparam int BW = $clog2(DW);

   typedef enum logic [2:0] {IDLE, SQUARE, CROSS, NUMER, DIVIDE, WRITE} state_type;

   state_type state_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;
   logic [NW-1:0] n_ff;
   logic signed [UW-1:0] num_ff [9];
   logic [3:0] idx_ff;
   logic [BW-1:0] bit_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] dvd_ff;
   logic [QB-1:0] quo_ff;
   logic neg_ff;
   logic zero_ff;
   logic signed [MW-1:0] mat_ff [9];

   logic signed [UW-1:0] cur_num;
   logic [UW-1:0] cur_mag;
   logic [DW-1:0] rem_sh, den2;
   logic signed [NW+1:0] n_s;

   always_comb begin
      cur_num = num_ff[idx_ff];
      cur_mag = cur_num[UW-1] ? UW'(-cur_num) : UW'(cur_num);
      rem_sh = {rem_ff[DW-2:0], dvd_ff[DW-1]};
      den2 = {{(DW-NW-1){1'b0}}, n_ff, 1'b0};
      n_s = $signed({2'b00, n_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         zero_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            mat_ff[i] <= (i % 4 == 0) ? MW'(1) <<< MATRIX_FRAC_BITS : '0;
         end
         idx_ff <= '0;
         bit_ff <= '0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  ww_ff <= quat_w * quat_w;
                  xx_ff <= quat_x * quat_x;
                  yy_ff <= quat_y * quat_y;
                  zz_ff <= quat_z * quat_z;
                  state_ff <= SQUARE;
               end
            end
            SQUARE: begin
               xy_ff <= quat_x * quat_y;
               zw_ff <= quat_z * quat_w;
               xz_ff <= quat_x * quat_z;
               yw_ff <= quat_y * quat_w;
               yz_ff <= quat_y * quat_z;
               xw_ff <= quat_x * quat_w;
               n_ff <= NW'(ww_ff) + NW'(xx_ff) + NW'(yy_ff) + NW'(zz_ff);
               state_ff <= CROSS;
            end
            CROSS: begin
               if (n_ff == '0) begin
                  zero_ff <= 1'b1;
                  for (int i = 0; i < 9; i++) begin
                     mat_ff[i] <= (i % 4 == 0) ? MW'(1) <<< MATRIX_FRAC_BITS : '0;
                  end
                  state_ff <= IDLE;
               end else begin
                  num_ff[0] <= UW'(n_s) - (UW'(yy_ff) + UW'(zz_ff)) * 2;
                  num_ff[1] <= (UW'(xy_ff) - UW'(zw_ff)) * 2;
                  num_ff[2] <= (UW'(xz_ff) + UW'(yw_ff)) * 2;
                  num_ff[3] <= (UW'(xy_ff) + UW'(zw_ff)) * 2;
                  num_ff[4] <= UW'(n_s) - (UW'(xx_ff) + UW'(zz_ff)) * 2;
                  num_ff[5] <= (UW'(yz_ff) - UW'(xw_ff)) * 2;
                  num_ff[6] <= (UW'(xz_ff) - UW'(yw_ff)) * 2;
                  num_ff[7] <= (UW'(yz_ff) + UW'(xw_ff)) * 2;
                  num_ff[8] <= UW'(n_s) - (UW'(xx_ff) + UW'(yy_ff)) * 2;
                  idx_ff <= '0;
                  state_ff <= NUMER;
               end
            end
            NUMER: begin
               // q = (2*mag<<F + n) / (2n)
               dvd_ff <= ({{(DW-UW){1'b0}}, cur_mag} << (MATRIX_FRAC_BITS + 1))
                         + DW'(n_ff);
               neg_ff <= cur_num[UW-1];
               rem_ff <= '0;
               quo_ff <= '0;
               bit_ff <= '0;
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               // only the low QB-1 quotient bits can be set; shift in all bits
               dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
               if (rem_sh >= den2) begin
                  rem_ff <= rem_sh - den2;
                  quo_ff <= {quo_ff[QB-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[QB-2:0], 1'b0};
               end
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == BW'(DW - 1)) state_ff <= WRITE;
            end
            WRITE: begin
               mat_ff[idx_ff] <= neg_ff ? MW'(-$signed({1'b0, quo_ff})) : MW'(quo_ff);
               if (idx_ff == 4'd8) begin
                  zero_ff <= 1'b0;
                  state_ff <= IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= NUMER;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign matrix = mat_ff;
   assign status.busy = (state_ff != IDLE);
   assign status.zero_quat = zero_ff;
endmodule

>>> hw/rtl/qrt_datapath.sv
// One point per cycle while out_ready is high: input register, nine products, row sums, round and clamp.
module qrt_datapath #(
   parameter int COORD_WIDTH = qrt_pkg::COORD_WIDTH_DEF,
   parameter int MATRIX_FRAC_BITS = qrt_pkg::MATRIX_FRAC_BITS_DEF,
   parameter int MW = MATRIX_FRAC_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic signed [COORD_WIDTH-1:0] in_z,
   input  logic                          in_last,
   input  logic signed [MW-1:0]          matrix [9],
   input  logic signed [COORD_WIDTH-1:0] shift [3],
   input  qrt_pkg::mat_status_type       status,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_x,
   output logic signed [COORD_WIDTH-1:0] out_y,
   output logic signed [COORD_WIDTH-1:0] out_z,
   output logic                          out_last,
   output logic                          out_zero
);
   localparam int PW = COORD_WIDTH + MW;
   localparam int SW = PW + 3;

   logic s1_valid_ff, s2_valid_ff;
   logic signed [COORD_WIDTH-1:0] p_ff [3];
   logic s1_last_ff;
   logic signed [PW-1:0] prod_ff [9];
   logic s2_last_ff;
   logic s1_go, s2_go;
   logic signed [SW-1:0] acc [3];
   logic signed [SW-MATRIX_FRAC_BITS-1:0] rnd [3];
   logic signed [COORD_WIDTH-1:0] sat [3];

   assign s2_go = !s2_valid_ff || out_ready;
   assign s1_go = !s1_valid_ff || s2_go;
   assign in_ready = s1_go;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = (SW'(shift[r]) <<< MATRIX_FRAC_BITS) + SW'(prod_ff[r*3])
                  + SW'(prod_ff[r*3+1]) + SW'(prod_ff[r*3+2])
                  + (SW'(1) <<< (MATRIX_FRAC_BITS - 1));
         rnd[r] = acc[r][SW-1:MATRIX_FRAC_BITS];
         if (rnd[r] > $signed((SW-MATRIX_FRAC_BITS)'({1'b0, {(COORD_WIDTH-1){1'b1}}})))
            sat[r] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         else if (rnd[r] < -$signed((SW-MATRIX_FRAC_BITS)'({1'b1, {(COORD_WIDTH-1){1'b0}}})))
            sat[r] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         else
            sat[r] = rnd[r][COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_go) s1_valid_ff <= in_valid;
         if (s2_go) s2_valid_ff <= s1_valid_ff;
      end
      if (s1_go && in_valid) begin
         p_ff[0] <= in_x;
         p_ff[1] <= in_y;
         p_ff[2] <= in_z;
         s1_last_ff <= in_last;
      end
      if (s2_go && s1_valid_ff) begin
         for (int i = 0; i < 9; i++) prod_ff[i] <= matrix[i] * p_ff[i % 3];
         s2_last_ff <= s1_last_ff;
      end
   end

   // sums, rounding and clamp run straight off the product stage
   assign out_valid = s2_valid_ff;
   assign out_x = sat[0];
   assign out_y = sat[1];
   assign out_z = sat[2];
   assign out_last = s2_last_ff;
   assign out_zero = status.zero_quat;
endmodule

>>> hw/rtl/quaternion_rigid_transform_core.sv
// Quaternion rigid transform: out = R * point + shift, Q16.16 coordinates.
// Channels:
//   csr_   write port; index 0..3 are quaternion w,x,y,z, 4..6 the shift.
//          A quaternion write starts a rebuild of the rotation matrix in one
//          shared divider, one quotient bit per cycle; an all-zero quaternion
//          skips the division and loads the identity matrix.
//          csr_ready and req_tready stay low until the rebuild is done.
//          Write only while no point is in flight.
//   req_   point beats: tdata = {z, y, x}, tlast marks the end of a group.
//   rsp_   result beats: tdata = {z, y, x}, tlast copied, tuser = zero
//          quaternion flag (identity used).
// A point accepted at req_ passes the two registered stages (input, then
// products; sums and clamp follow combinationally) before rsp_ can take it;
// one point per cycle is sustained while rsp_tready is high and no rebuild runs.
// Reset loads quaternion (16384,0,0,0), zero shift, identity matrix and
// clears the flag. When rsp_tready is low the pipeline holds and req_tready
// drops once both stages are full; no beat is lost.
module quaternion_rigid_transform_core #(
   parameter int COORD_WIDTH = qrt_pkg::COORD_WIDTH_DEF,
   parameter int MATRIX_FRAC_BITS = qrt_pkg::MATRIX_FRAC_BITS_DEF,
   localparam int TW = ((3 * COORD_WIDTH) + 7) / 8 * 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [qrt_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                  csr_data,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [TW-1:0]                           req_tdata,  // point_x, point_y, point_z
   input  logic                                    req_tlast,  // last_point
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [TW-1:0]                           rsp_tdata,  // out_x, out_y, out_z
   output logic                                    rsp_tlast,  // last_out
   output logic                                    rsp_tuser   // zero_quaternion
);
   localparam int MW = MATRIX_FRAC_BITS + 2;
   localparam int CW = COORD_WIDTH;

   logic signed [qrt_pkg::QUAT_WIDTH-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [CW-1:0] shift_ff [3];
   logic start_ff;
   logic signed [MW-1:0] matrix [9];
   qrt_pkg::mat_status_type status;
   logic signed [CW-1:0] ox, oy, oz;
   logic rebuild_busy;
   logic dp_in_ready;

   // hold both inputs from the quaternion write until the matrix is ready
   assign rebuild_busy = status.busy || start_ff;
   assign csr_ready = !rebuild_busy;
   assign req_tready = dp_in_ready && !rebuild_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         qw_ff <= 16'sd16384;
         qx_ff <= '0;
         qy_ff <= '0;
         qz_ff <= '0;
         for (int i = 0; i < 3; i++) shift_ff[i] <= '0;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (qrt_pkg::csr_index_type'(csr_index))
               qrt_pkg::REG_QUAT_W: begin
                  qw_ff <= csr_data[qrt_pkg::QUAT_WIDTH-1:0]; start_ff <= 1'b1;
               end
               qrt_pkg::REG_QUAT_X: begin
                  qx_ff <= csr_data[qrt_pkg::QUAT_WIDTH-1:0]; start_ff <= 1'b1;
               end
               qrt_pkg::REG_QUAT_Y: begin
                  qy_ff <= csr_data[qrt_pkg::QUAT_WIDTH-1:0]; start_ff <= 1'b1;
               end
               qrt_pkg::REG_QUAT_Z: begin
                  qz_ff <= csr_data[qrt_pkg::QUAT_WIDTH-1:0]; start_ff <= 1'b1;
               end
               qrt_pkg::REG_SHIFT_X: shift_ff[0] <= csr_data;
               qrt_pkg::REG_SHIFT_Y: shift_ff[1] <= csr_data;
               qrt_pkg::REG_SHIFT_Z: shift_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   qrt_matrix_builder #(.MATRIX_FRAC_BITS(MATRIX_FRAC_BITS), .MW(MW)) u_builder (
      .clock, .reset, .start(start_ff),
      .quat_w(qw_ff), .quat_x(qx_ff), .quat_y(qy_ff), .quat_z(qz_ff),
      .matrix, .status
   );

   qrt_datapath #(.COORD_WIDTH(CW), .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS), .MW(MW)) u_dp (
      .clock, .reset,
      .in_valid(req_tvalid && !rebuild_busy), .in_ready(dp_in_ready),
      .in_x(req_tdata[CW-1:0]), .in_y(req_tdata[2*CW-1:CW]),
      .in_z(req_tdata[3*CW-1:2*CW]), .in_last(req_tlast),
      .matrix, .shift(shift_ff), .status,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_x(ox), .out_y(oy), .out_z(oz),
      .out_last(rsp_tlast), .out_zero(rsp_tuser)
   );

   assign rsp_tdata = TW'({oz, oy, ox});
endmodule

>>> sim/tb_quaternion_rigid_transform_core.sv
`timescale 1ns / 1ps

module tb_quaternion_rigid_transform_core;

   localparam int CW = 32;
   localparam int FRAC = 16;
   localparam int TW = 96;
   localparam int REBUILD_WAIT = 1200;   // matrix rebuild after a quaternion write
   localparam int IDLE_LIMIT = 6000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PER_PHASE = 66;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      logic signed [CW-1:0] x, y, z;
      logic                 last;
      logic                 zq;
   } point_beat_type;

   class transform_scoreboard_type;
      longint         qw, qx, qy, qz;
      longint         sx, sy, sz;
      longint         rot[9];
      bit             zero_flag;
      point_beat_type pending[$];
      int             errors;

      function new();
         qw = 16384; qx = 0; qy = 0; qz = 0;
         sx = 0; sy = 0; sz = 0;
         rebuild();
         zero_flag = 0;
         errors = 0;
      endfunction

      function longint div_round(longint num, longint n);
         longint mag;
         longint q;
         mag = (num < 0 ? -num : num) << FRAC;
         q = (2 * mag + n) / (2 * n);
         return num < 0 ? -q : q;
      endfunction

      function void rebuild();
         longint xx, yy, zz, n;
         longint num[9];
         xx = qx * qx; yy = qy * qy; zz = qz * qz;
         n = qw * qw + xx + yy + zz;
         if (n == 0) begin
            foreach (rot[i]) rot[i] = (i % 4 == 0) ? (64'sd1 << FRAC) : 0;
            zero_flag = 1;
            return;
         end
         num[0] = n - 2 * (yy + zz);
         num[1] = 2 * (qx * qy - qz * qw);
         num[2] = 2 * (qx * qz + qy * qw);
         num[3] = 2 * (qx * qy + qz * qw);
         num[4] = n - 2 * (xx + zz);
         num[5] = 2 * (qy * qz - qx * qw);
         num[6] = 2 * (qx * qz - qy * qw);
         num[7] = 2 * (qy * qz + qx * qw);
         num[8] = n - 2 * (xx + yy);
         foreach (rot[i]) rot[i] = div_round(num[i], n);
         zero_flag = 0;
      endfunction

      function void write_reg(qrt_pkg::csr_index_type idx, logic [CW-1:0] data);
         longint q;
         q = longint'($signed(data[15:0]));
         case (idx)
            qrt_pkg::REG_QUAT_W: begin qw = q; rebuild(); end
            qrt_pkg::REG_QUAT_X: begin qx = q; rebuild(); end
            qrt_pkg::REG_QUAT_Y: begin qy = q; rebuild(); end
            qrt_pkg::REG_QUAT_Z: begin qz = q; rebuild(); end
            qrt_pkg::REG_SHIFT_X: sx = longint'($signed(data));
            qrt_pkg::REG_SHIFT_Y: sy = longint'($signed(data));
            qrt_pkg::REG_SHIFT_Z: sz = longint'($signed(data));
            default: ;
         endcase
      endfunction

      function logic signed [CW-1:0] transform_row(int r, longint sh, longint p[3]);
         longint acc;
         acc = sh * (64'sd1 << FRAC);
         for (int c = 0; c < 3; c++) acc += rot[r * 3 + c] * p[c];
         acc = (acc + (64'sd1 << (FRAC - 1))) >>> FRAC;
         if (acc > longint'(CMAX)) return CMAX;
         if (acc < longint'(CMIN)) return CMIN;
         return acc[CW-1:0];
      endfunction

      function void note_point(logic [TW-1:0] data, logic last);
         longint p[3];
         point_beat_type e;
         p[0] = longint'($signed(data[CW-1:0]));
         p[1] = longint'($signed(data[2*CW-1:CW]));
         p[2] = longint'($signed(data[3*CW-1:2*CW]));
         e.x = transform_row(0, sx, p);
         e.y = transform_row(1, sy, p);
         e.z = transform_row(2, sz, p);
         e.last = last;
         e.zq = zero_flag;
         pending.insert(pending.size(), e);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_result(logic [TW-1:0] data, logic last, logic zq);
         point_beat_type e;
         if (pending.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
         end
         e = pending.pop_front();
         if ($signed(data[CW-1:0]) !== e.x) report("out_x", $signed(data[CW-1:0]), e.x);
         if ($signed(data[2*CW-1:CW]) !== e.y)
            report("out_y", $signed(data[2*CW-1:CW]), e.y);
         if ($signed(data[3*CW-1:2*CW]) !== e.z)
            report("out_z", $signed(data[3*CW-1:2*CW]), e.z);
         if (last !== e.last) report("last_out", last, e.last);
         if (zq !== e.zq) report("zero_quaternion", zq, e.zq);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [qrt_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CW-1:0] csr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [TW-1:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [TW-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   transform_scoreboard_type sb = new();
   int  idle_cycles = 0;
   int  hold_request = 0;
   bit  no_idle = 0;

   quaternion_rigid_transform_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (req_tvalid && req_tready) sb.note_point(req_tdata, req_tlast);
      if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, mostly short, with a forced long hold on request
   initial begin
      int low_left;
      low_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            low_left = hold_request;
            hold_request = 0;
         end
         if (low_left > 0) begin
            rsp_tready <= 0;
            low_left--;
         end else if (no_idle || $urandom_range(0, 9) < 7) begin
            rsp_tready <= 1;
         end else begin
            rsp_tready <= 0;
            low_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
         end
      end
   end

   task write_csr(qrt_pkg::csr_index_type idx, logic [CW-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
      if (idx <= qrt_pkg::REG_QUAT_Z) repeat (REBUILD_WAIT) @(negedge clock);
   endtask

   task set_pose(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                 logic [CW-1:0] tx, logic [CW-1:0] ty, logic [CW-1:0] tz);
      write_csr(qrt_pkg::REG_QUAT_W, {16'($urandom), w});
      write_csr(qrt_pkg::REG_QUAT_X, {16'($urandom), x});
      write_csr(qrt_pkg::REG_QUAT_Y, {16'($urandom), y});
      write_csr(qrt_pkg::REG_QUAT_Z, {16'($urandom), z});
      write_csr(qrt_pkg::REG_SHIFT_X, tx);
      write_csr(qrt_pkg::REG_SHIFT_Y, ty);
      write_csr(qrt_pkg::REG_SHIFT_Z, tz);
   endtask

   task send_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z, logic last);
      int gap;
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      gap = 0;
      if (!no_idle && $urandom_range(0, 9) < 4)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return CW'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
         2: return ($urandom_range(0, 1)) ? CMAX - $urandom_range(0, 3) : CMIN + $urandom_range(0, 3);
         default: return CW'($signed($urandom_range(0, 2 ** 27)) - 2 ** 26);
      endcase
   endfunction

   task directed_points();
      send_point(0, 0, 0, 0);
      send_point(CMAX, CMAX, CMAX, 0);
      send_point(CMIN, CMIN, CMIN, 1);
      send_point(CMAX, CMIN, 1, 0);
      send_point(CMIN, CMAX, -1, 1);
      send_point(32'h0000_8000, -32'sh8000, 32'h0001_0000, 0);
      send_point(1, -1, 32'h7fff, 1);
      send_point(32'haaaa_5555, 32'h5555_aaaa, 32'hffff_0000, 1);
   endtask

   task random_points();
      int left;
      left = RANDOM_PER_PHASE;
      while (left > 0) begin
         // groups of a few points ending in a last marker
         send_point(rand_coord(), rand_coord(), rand_coord(),
                    (left == 1) || ($urandom_range(0, 5) == 0));
         left--;
      end
   endtask

   task drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      repeat (2) @(negedge clock);

      // reset pose: identity, no shift
      directed_points();
      random_points();
      drain();

      // extremes of every register, plus an ignored index
      set_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000, CMAX, CMIN, CMAX);
      write_csr(qrt_pkg::REG_NONE, $urandom);
      directed_points();
      hold_request = HOLD_CYCLES;
      random_points();
      drain();

      // all-zero quaternion falls back to identity
      set_pose(0, 0, 0, 0, CMIN, CMAX, 0);
      directed_points();
      random_points();
      drain();

      set_pose(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, CMIN);
      no_idle = 1;
      random_points();
      drain();
      no_idle = 0;

      // a single nonzero part after a degenerate setting
      set_pose(0, 0, 0, 0, 0, 0, 0);
      write_csr(qrt_pkg::REG_QUAT_Y, 16'h0001);
      random_points();
      drain();

      repeat (3) begin
         set_pose(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  rand_coord(), rand_coord(), rand_coord());
         random_points();
         drain();
      end

      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
